@@ hdl/owdm_pkg.sv @@
// Shared constants, types and cosine/reciprocal tables of the omni wheel drive mixer.
package owdm_pkg;

	localparam int COS_FRAC_BITS = 15;

	localparam int DIR_W     = 10;
	localparam int HEAD_W    = 9;
	localparam int WHEEL_W   = 9;
	localparam int REG_W     = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_POWER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_THRESHOLD   = 2'd3;

	localparam logic [REG_W-1:0] BASE_SPEED_RST       = 8'd0;
	localparam logic [REG_W-1:0] CORRECTION_POWER_RST = 8'd30;
	localparam logic [REG_W-1:0] DEAD_BAND_RST        = 8'd10;
	localparam logic [REG_W-1:0] TURN_THRESHOLD_RST   = 8'd40;

	localparam int DRIVE_MAX = 255;

	// angles
	localparam int QUARTER_DEG  = 90;
	localparam int FULL_DEG     = 360;
	localparam int OCTANT_DEG   = 45;
	localparam int WHEEL1_ANGLE = 45 + QUARTER_DEG;
	localparam int DIR_BIAS     = WHEEL1_ANGLE + 2 * FULL_DEG;
	localparam int DIR_EXT_W    = 12;
	localparam int ANG_W        = 11;
	localparam int ANG_R_W      = 9;
	localparam int M_W          = $clog2(QUARTER_DEG);

	// spin value 200*|h|/180 = 10*|h|/9
	localparam int SPIN_GAIN     = 200;
	localparam int SPIN_SPAN     = 180;
	localparam int SPIN_MUL      = SPIN_GAIN / 20;
	localparam int SPIN_DIV      = SPIN_SPAN / 20;
	localparam int SPIN_SHIFT    = 16;
	localparam int SPIN_RECIP    = (2 ** SPIN_SHIFT + SPIN_DIV - 1) / SPIN_DIV;
	localparam int SPIN_N_W      = 12;
	localparam int SPIN_RECIP_W  = SPIN_SHIFT - 3;
	localparam int SPIN_PROD_W   = SPIN_N_W + SPIN_RECIP_W;

	// datapath widths
	localparam int COS_W       = COS_FRAC_BITS + 1;
	localparam int RECIP_EXTRA = 9;
	localparam int RECIP_W     = COS_FRAC_BITS + RECIP_EXTRA + 1;
	localparam int QA_PROD_W   = REG_W + RECIP_W;
	localparam int QUOT_W      = REG_W + COS_FRAC_BITS + 1;
	localparam int Q2_W        = QUOT_W + 1;
	localparam int DIV_W       = QUOT_W + COS_W;
	localparam int NUM_W       = REG_W + 2 * COS_FRAC_BITS;
	localparam int TERM_W      = REG_W + COS_W;
	localparam int SUM_W       = REG_W + COS_FRAC_BITS + 4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam longint PI_Q30     = 64'sd3373259426;
	localparam longint ONE_Q30    = longint'(1) << 30;
	localparam int     FRAC_SHIFT = 30 - COS_FRAC_BITS;

	typedef struct packed {
		logic [REG_W-1:0] base_speed;
		logic [REG_W-1:0] correction_power;
		logic [REG_W-1:0] dead_band;
		logic [REG_W-1:0] turn_threshold;
	} owdm_cfg_t;

	typedef struct packed {
		logic                      spin;
		logic signed [WHEEL_W-1:0] spin_val;
		logic signed [WHEEL_W-1:0] corr;
		logic [1:0]                quad;
		logic [M_W-1:0]            m;
	} owdm_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} owdm_qstat_t;

	typedef logic [QUARTER_DEG-1:0][COS_W-1:0]   cos_tab_t;
	typedef logic [QUARTER_DEG-1:0][RECIP_W-1:0] recip_tab_t;

	// shift-and-subtract quotient of nonnegative operands, for table building
	function automatic longint udiv(longint num, longint den);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int i = 62; i >= 0; i--) begin
			r = (r << 1) | ((num >>> i) & longint'(1));
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | longint'(1);
			end
		end
		return q;
	endfunction

	function automatic longint octant_q30(longint deg, bit want_sin);
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint n;
		x = deg * PI_Q30 / 180;
		x2 = (x * x) >>> 30;
		term = want_sin ? x : ONE_Q30;
		sum = term;
		n = want_sin ? 1 : 0;
		for (int k = 1; k <= 5; k++) begin
			term = udiv((term * x2) >>> 30, (n + 1) * (n + 2));
			n = n + 2;
			if (k[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum;
	endfunction

	function automatic longint to_frac(longint v);
		return (v + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
	endfunction

	function automatic cos_tab_t build_quarter(bit want_sin);
		cos_tab_t t;
		longint v;
		for (int m = 0; m < QUARTER_DEG; m++) begin
			if (m <= OCTANT_DEG)
				v = to_frac(octant_q30(longint'(m), want_sin));
			else
				v = to_frac(octant_q30(longint'(QUARTER_DEG - m), !want_sin));
			t[m] = COS_W'(v);
		end
		return t;
	endfunction

	function automatic cos_tab_t build_maxc();
		cos_tab_t c;
		cos_tab_t s;
		cos_tab_t t;
		c = build_quarter(1'b0);
		s = build_quarter(1'b1);
		for (int m = 0; m < QUARTER_DEG; m++)
			t[m] = (c[m] > s[m]) ? c[m] : s[m];
		return t;
	endfunction

	function automatic recip_tab_t build_recip();
		cos_tab_t   mx;
		recip_tab_t r;
		mx = build_maxc();
		for (int m = 0; m < QUARTER_DEG; m++)
			r[m] = RECIP_W'(udiv(longint'(1) << (2 * COS_FRAC_BITS + RECIP_EXTRA),
				longint'(mx[m])));
		return r;
	endfunction

	localparam cos_tab_t   COS_TAB   = build_quarter(1'b0);
	localparam cos_tab_t   SIN_TAB   = build_quarter(1'b1);
	localparam cos_tab_t   MAXC_TAB  = build_maxc();
	localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

@@ hdl/owdm_ifs.sv @@
// Channel interfaces: command input, drive output and register write port.
interface owdm_cmd_if;
	import owdm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DIR_W-1:0]  direction_deg;
	logic signed [HEAD_W-1:0] heading_error;
	modport source(output valid, direction_deg, heading_error, input ready);
	modport sink(input valid, direction_deg, heading_error, output ready);
endinterface

interface owdm_drive_if;
	import owdm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [WHEEL_W-1:0] wheel_one;
	logic signed [WHEEL_W-1:0] wheel_two;
	logic signed [WHEEL_W-1:0] wheel_three;
	logic signed [WHEEL_W-1:0] wheel_four;
	logic                      spinning;
	modport source(output valid, wheel_one, wheel_two, wheel_three, wheel_four, spinning,
		input ready);
	modport sink(input valid, wheel_one, wheel_two, wheel_three, wheel_four, spinning,
		output ready);
endinterface

interface owdm_cfg_if;
	import owdm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [REG_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/owdm_cfg_regs.sv @@
// Configuration register file of the omni wheel drive mixer.
module owdm_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	owdm_cfg_if.sink            cfg,
	output owdm_pkg::owdm_cfg_t regs
);
	import owdm_pkg::*;

	owdm_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.base_speed       <= BASE_SPEED_RST;
			regs_q.correction_power <= CORRECTION_POWER_RST;
			regs_q.dead_band        <= DEAD_BAND_RST;
			regs_q.turn_threshold   <= TURN_THRESHOLD_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_BASE_SPEED:       regs_q.base_speed       <= cfg.data;
				REG_CORRECTION_POWER: regs_q.correction_power <= cfg.data;
				REG_DEAD_BAND:        regs_q.dead_band        <= cfg.data;
				REG_TURN_THRESHOLD:   regs_q.turn_threshold   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/owdm_front.sv @@
// Front end: accepts command beats and classifies them into spin or drive work.
module owdm_front (
	owdm_cmd_if.sink              cmd,
	input  owdm_pkg::owdm_cfg_t   regs,
	input  owdm_pkg::owdm_qstat_t qstat,
	output logic                  push,
	output owdm_pkg::owdm_cmd_t   item
);
	import owdm_pkg::*;

	logic signed [HEAD_W:0]      h_x;
	logic signed [HEAD_W:0]      thr_x;
	logic signed [HEAD_W:0]      db_x;
	logic signed [WHEEL_W-1:0]   pw_x;
	logic                        turn_left;
	logic                        turn_right;
	logic                        in_band;
	logic [HEAD_W-1:0]           ah;
	logic [SPIN_N_W-1:0]         spin_n;
	logic [SPIN_PROD_W-1:0]      spin_prod;
	logic [SPIN_PROD_W-SPIN_SHIFT-1:0] spin_raw;
	logic [REG_W-1:0]            spin_mag;
	logic signed [DIR_EXT_W-1:0] ang_x;
	logic [ANG_W-1:0]            ang;
	logic [ANG_R_W-1:0]          ang_r;
	logic [1:0]                  quad;
	logic [ANG_R_W-1:0]          quad_base;

	assign cmd.ready = !qstat.full;
	assign push = cmd.valid && cmd.ready;

	always_comb begin
		h_x   = (HEAD_W+1)'(cmd.heading_error);
		thr_x = (HEAD_W+1)'({1'b0, regs.turn_threshold});
		db_x  = (HEAD_W+1)'({1'b0, regs.dead_band});
		pw_x  = WHEEL_W'({1'b0, regs.correction_power});

		turn_left  = h_x >= thr_x;
		turn_right = h_x <= -thr_x;
		in_band    = (h_x <= db_x) && (h_x >= -db_x);

		ah        = (h_x < 0) ? HEAD_W'(-h_x) : HEAD_W'(h_x);
		spin_n    = SPIN_N_W'(ah) * SPIN_N_W'(SPIN_MUL);
		spin_prod = SPIN_PROD_W'(spin_n) * SPIN_PROD_W'(SPIN_RECIP);
		spin_raw  = spin_prod[SPIN_PROD_W-1:SPIN_SHIFT];
		spin_mag  = (spin_raw > DRIVE_MAX) ? REG_W'(DRIVE_MAX) : spin_raw[REG_W-1:0];

		ang_x = DIR_EXT_W'(DIR_BIAS) - DIR_EXT_W'(cmd.direction_deg);
		ang   = ang_x[ANG_W-1:0];
		if (ang >= ANG_W'(3 * FULL_DEG))
			ang_r = ANG_R_W'(ang - ANG_W'(3 * FULL_DEG));
		else if (ang >= ANG_W'(2 * FULL_DEG))
			ang_r = ANG_R_W'(ang - ANG_W'(2 * FULL_DEG));
		else if (ang >= ANG_W'(FULL_DEG))
			ang_r = ANG_R_W'(ang - ANG_W'(FULL_DEG));
		else
			ang_r = ANG_R_W'(ang);

		if (ang_r >= ANG_R_W'(3 * QUARTER_DEG)) begin
			quad      = 2'd3;
			quad_base = ANG_R_W'(3 * QUARTER_DEG);
		end else if (ang_r >= ANG_R_W'(2 * QUARTER_DEG)) begin
			quad      = 2'd2;
			quad_base = ANG_R_W'(2 * QUARTER_DEG);
		end else if (ang_r >= ANG_R_W'(QUARTER_DEG)) begin
			quad      = 2'd1;
			quad_base = ANG_R_W'(QUARTER_DEG);
		end else begin
			quad      = 2'd0;
			quad_base = '0;
		end

		item.spin     = turn_left || turn_right;
		item.spin_val = turn_left ? -WHEEL_W'({1'b0, spin_mag}) : WHEEL_W'({1'b0, spin_mag});
		if (in_band)
			item.corr = '0;
		else if (h_x > 0)
			item.corr = -pw_x;
		else
			item.corr = pw_x;
		item.quad = quad;
		item.m    = M_W'(ang_r - quad_base);
	end

endmodule

@@ hdl/owdm_queue.sv @@
// Four-entry queue between the front end and the back-end pipeline.
module owdm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  owdm_pkg::owdm_cmd_t   wr_item,
	input  logic                  pop,
	output owdm_pkg::owdm_cmd_t   rd_item,
	output owdm_pkg::owdm_qstat_t qstat
);
	import owdm_pkg::*;

	owdm_cmd_t         slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign qstat.full  = count_q == (QPTR_W+1)'(QDEPTH);
	assign qstat.empty = count_q == '0;
	assign rd_item     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ hdl/owdm_back.sv @@
// Back-end pipeline: cosine lookup, correction quotient, wheel sums and drive register.
module owdm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  owdm_pkg::owdm_cmd_t   item,
	input  owdm_pkg::owdm_qstat_t qstat,
	output logic                  pop,
	input  logic [owdm_pkg::REG_W-1:0] base_speed,
	owdm_drive_if.source          drive
);
	import owdm_pkg::*;

	localparam logic [SUM_W-1:0] DRIVE_LIM = SUM_W'(DRIVE_MAX) << COS_FRAC_BITS;

	logic adv;

	logic                 v_s1;
	owdm_cmd_t            cmd_s1;
	logic [COS_W-1:0]     cos_s1;
	logic [COS_W-1:0]     sin_s1;
	logic [COS_W-1:0]     maxc_s1;
	logic [RECIP_W-1:0]   recip_s1;

	logic                 v_s2;
	owdm_cmd_t            cmd_s2;
	logic [TERM_W-1:0]    pc_s2;
	logic [TERM_W-1:0]    ps_s2;
	logic [QA_PROD_W-1:0] qa_prod_s2;
	logic [COS_W-1:0]     maxc_s2;
	logic [REG_W-1:0]     mag_s2;

	logic                 v_s3;
	owdm_cmd_t            cmd_s3;
	logic [TERM_W-1:0]    pc_s3;
	logic [TERM_W-1:0]    ps_s3;
	logic [QUOT_W-1:0]    qa_s3;
	logic [DIV_W-1:0]     qd_s3;
	logic [COS_W-1:0]     maxc_s3;
	logic [REG_W-1:0]     mag_s3;

	logic                 v_s4;
	owdm_cmd_t            cmd_s4;
	logic [TERM_W-1:0]    pc_s4;
	logic [TERM_W-1:0]    ps_s4;
	logic signed [Q2_W-1:0] q2_s4;

	logic [REG_W-1:0]     mag_s1;
	logic [QUOT_W-1:0]    qa_s2;
	logic [DIV_W-1:0]     rem_s3;
	logic [QUOT_W-1:0]    q2_mag_s3;
	logic signed [WHEEL_W-1:0] wheel_s4 [4];

	function automatic logic signed [WHEEL_W-1:0] wheel_calc(
		logic [1:0]                qk,
		logic [TERM_W-1:0]         pc,
		logic [TERM_W-1:0]         ps,
		logic signed [Q2_W-1:0]    q2,
		logic signed [WHEEL_W-1:0] corr
	);
		logic [TERM_W-1:0]       tmag;
		logic signed [SUM_W-1:0] term;
		logic signed [SUM_W-1:0] v;
		logic [SUM_W-1:0]        av;
		logic [REG_W-1:0]        w;
		tmag = qk[0] ? ps : pc;
		term = SUM_W'(tmag);
		if (qk[0] ^ qk[1])
			term = -term;
		v  = term + SUM_W'(q2) + (SUM_W'(corr) <<< COS_FRAC_BITS);
		av = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
		w  = (av >= DRIVE_LIM) ? REG_W'(DRIVE_MAX) : av[COS_FRAC_BITS +: REG_W];
		return v[SUM_W-1] ? -WHEEL_W'({1'b0, w}) : WHEEL_W'({1'b0, w});
	endfunction

	assign adv = !drive.valid || drive.ready;
	assign pop = adv && !qstat.empty;

	always_comb begin
		mag_s1    = cmd_s1.corr[WHEEL_W-1] ? REG_W'(-cmd_s1.corr) : REG_W'(cmd_s1.corr);
		qa_s2     = qa_prod_s2[QA_PROD_W-1:RECIP_EXTRA];
		rem_s3    = DIV_W'({mag_s3, {(2*COS_FRAC_BITS){1'b0}}}) - qd_s3;
		q2_mag_s3 = (rem_s3 >= DIV_W'(maxc_s3)) ? qa_s3 + 1'b1 : qa_s3;
		for (int k = 0; k < 4; k++)
			wheel_s4[k] = wheel_calc(cmd_s4.quad + 2'(k), pc_s4, ps_s4, q2_s4, cmd_s4.corr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			drive.valid <= 1'b0;
		end else if (adv) begin
			v_s1        <= !qstat.empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			drive.valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= item;
			cos_s1   <= COS_TAB[item.m];
			sin_s1   <= SIN_TAB[item.m];
			maxc_s1  <= MAXC_TAB[item.m];
			recip_s1 <= RECIP_TAB[item.m];

			cmd_s2     <= cmd_s1;
			pc_s2      <= TERM_W'(base_speed) * TERM_W'(cos_s1);
			ps_s2      <= TERM_W'(base_speed) * TERM_W'(sin_s1);
			qa_prod_s2 <= QA_PROD_W'(mag_s1) * QA_PROD_W'(recip_s1);
			maxc_s2    <= maxc_s1;
			mag_s2     <= mag_s1;

			cmd_s3  <= cmd_s2;
			pc_s3   <= pc_s2;
			ps_s3   <= ps_s2;
			qa_s3   <= qa_s2;
			qd_s3   <= DIV_W'(qa_s2) * DIV_W'(maxc_s2);
			maxc_s3 <= maxc_s2;
			mag_s3  <= mag_s2;

			cmd_s4 <= cmd_s3;
			pc_s4  <= pc_s3;
			ps_s4  <= ps_s3;
			q2_s4  <= cmd_s3.corr[WHEEL_W-1] ? -Q2_W'({1'b0, q2_mag_s3})
			                                 : Q2_W'({1'b0, q2_mag_s3});

			drive.spinning <= cmd_s4.spin;
			if (cmd_s4.spin) begin
				drive.wheel_one   <= cmd_s4.spin_val;
				drive.wheel_two   <= cmd_s4.spin_val;
				drive.wheel_three <= cmd_s4.spin_val;
				drive.wheel_four  <= cmd_s4.spin_val;
			end else begin
				drive.wheel_one   <= wheel_s4[0];
				drive.wheel_two   <= wheel_s4[1];
				drive.wheel_three <= wheel_s4[2];
				drive.wheel_four  <= wheel_s4[3];
			end
		end
	end

endmodule

@@ hdl/omni_wheel_drive_mixer.sv @@
// Top level of the four-wheel omni drive mixer.
// Takes one command beat (direction, heading error) per cycle and returns one drive beat with
// four wheel values and a spin flag, in order. With the drive side ready the sustained rate is
// one beat per clock. An accepted beat passes from the front end into a four-entry queue,
// then through four back-end stages and the drive register, which all advance together, to
// the drive channel. The back end holds while a drive beat waits, and the queue keeps
// taking commands until its four entries are used. Register writes are taken every cycle.
module omni_wheel_drive_mixer (
	input logic          clk,
	input logic          arst_n,
	owdm_cfg_if.sink     cfg,
	owdm_cmd_if.sink     cmd,
	owdm_drive_if.source drive
);
	import owdm_pkg::*;

	owdm_cfg_t   regs;
	owdm_cmd_t   wr_item;
	owdm_cmd_t   rd_item;
	owdm_qstat_t qstat;
	logic        push;
	logic        pop;

	owdm_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	owdm_front u_front (
		.cmd   (cmd),
		.regs  (regs),
		.qstat (qstat),
		.push  (push),
		.item  (wr_item)
	);

	owdm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.qstat   (qstat)
	);

	owdm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (rd_item),
		.qstat      (qstat),
		.pop        (pop),
		.base_speed (regs.base_speed),
		.drive      (drive)
	);

endmodule

@@ hdl/owdm_checker.sv @@
// Port-level checks of the omni wheel drive mixer and their binding to the top level.
module owdm_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  cmd_ready,
	input logic                                  drive_valid,
	input logic                                  drive_ready,
	input logic signed [owdm_pkg::WHEEL_W-1:0]   wheel_one,
	input logic signed [owdm_pkg::WHEEL_W-1:0]   wheel_two,
	input logic signed [owdm_pkg::WHEEL_W-1:0]   wheel_three,
	input logic signed [owdm_pkg::WHEEL_W-1:0]   wheel_four,
	input logic                                  spinning
);
	import owdm_pkg::*;

	localparam logic signed [WHEEL_W-1:0] WHEEL_MIN = {1'b1, {(WHEEL_W-1){1'b0}}};

	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && !drive_ready |=> drive_valid && $stable(wheel_one) &&
		$stable(wheel_two) && $stable(wheel_three) && $stable(wheel_four) && $stable(spinning))
		else $error("drive beat changed while stalled");

	a_spin_equal: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && spinning |-> wheel_two == wheel_one && wheel_three == wheel_one &&
		wheel_four == wheel_one)
		else $error("spin beat with unequal wheels");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> wheel_one != WHEEL_MIN && wheel_two != WHEEL_MIN &&
		wheel_three != WHEEL_MIN && wheel_four != WHEEL_MIN)
		else $error("wheel value beyond clamp");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> drive_valid)
		else $error("command stalled with no drive beat pending");

endmodule

bind omni_wheel_drive_mixer owdm_checker u_owdm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_ready   (cmd.ready),
	.drive_valid (drive.valid),
	.drive_ready (drive.ready),
	.wheel_one   (drive.wheel_one),
	.wheel_two   (drive.wheel_two),
	.wheel_three (drive.wheel_three),
	.wheel_four  (drive.wheel_four),
	.spinning    (drive.spinning)
);
